/* rtl/bbm_pkg.sv */
// Package: shared types and constants for the billboard basis matrix.
package bbm_pkg;

  localparam int unsigned InW = 32;
  localparam int unsigned OutW = 16;
  localparam int unsigned NumCfg = 2;
  localparam int unsigned CfgIdxW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_X_ENABLE = 1'b0,
    CFG_Y_ENABLE = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [InW-1:0] eye_x;
    logic signed [InW-1:0] eye_y;
    logic signed [InW-1:0] eye_z;
    logic signed [InW-1:0] target_x;
    logic signed [InW-1:0] target_y;
    logic signed [InW-1:0] target_z;
    logic signed [InW-1:0] up_x;
    logic signed [InW-1:0] up_y;
    logic signed [InW-1:0] up_z;
  } cam_item_t;

  typedef struct packed {
    logic signed [OutW-1:0] right_x;
    logic signed [OutW-1:0] right_y;
    logic signed [OutW-1:0] right_z;
    logic signed [OutW-1:0] upward_x;
    logic signed [OutW-1:0] upward_y;
    logic signed [OutW-1:0] upward_z;
    logic signed [OutW-1:0] forward_x;
    logic signed [OutW-1:0] forward_y;
    logic signed [OutW-1:0] forward_z;
    logic                   degenerate;
  } basis_item_t;

  // item lane status that travels with each item down the pipeline
  typedef struct packed {
    logic bypass;
    logic ymode;
    logic degen;
  } lane_ctl_t;

endpackage

/* rtl/bbm_if.sv */
// Interfaces: valid/ready channels for camera items and basis items.
interface bbm_cam_if;
  import bbm_pkg::*;
  logic      valid;
  logic      ready;
  cam_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bbm_basis_if;
  import bbm_pkg::*;
  logic        valid;
  logic        ready;
  basis_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/bbm_norm.sv */
// Pipelined normalizer: 3-vector in, Q.30 unit vector out.
module bbm_norm #(
  parameter int unsigned InBits = 64,
  parameter int unsigned TagW = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic signed [InBits-1:0] vec_i [3],
  input  logic [TagW-1:0]          tag_i,
  output logic                     valid_o,
  output logic                     zero_o,
  output logic signed [31:0]       unit_o [3],
  output logic [TagW-1:0]          tag_o
);
  // Stages: 0 magnitude/scale, 1 squares, 2..33 square root (2 bits each),
  // 34..95 quotient (1 bit each); sign applied at the output.
  localparam int unsigned SqrtSt = 32;
  localparam int unsigned DivSt = 32;
  localparam int unsigned Depth = 2 + SqrtSt + DivSt;
  localparam int unsigned ShW = $clog2(InBits + 1);

  typedef struct packed {
    logic            zero;
    logic [2:0]      neg;
    logic [TagW-1:0] tag;
  } side_t;

  logic [Depth-1:0] v_q;
  side_t            sd_q [Depth];

  // stage 0: magnitudes, scale largest into [2^29, 2^30)
  logic [InBits-1:0] mag [3];
  logic [InBits-1:0] mx;
  logic [ShW-1:0]    lz;
  logic [29:0]       m0_d [3];
  logic [29:0]       m0_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = vec_i[i][InBits-1] ? InBits'(-vec_i[i]) : InBits'(vec_i[i]);
    end
    mx = mag[0] | mag[1] | mag[2];
    lz = ShW'(InBits);
    for (int b = 0; b < InBits; b++) begin
      if (mx[b]) lz = ShW'(b);
    end
    for (int i = 0; i < 3; i++) begin
      if (lz >= ShW'(29)) m0_d[i] = 30'(mag[i] >> (lz - ShW'(29)));
      else m0_d[i] = 30'(mag[i] << (ShW'(29) - lz));
    end
  end

  // stage 1: sum of squares
  logic [61:0] sq_q;
  logic [29:0] m1_q [3];

  // sqrt pipeline; the partial root sits high in the word until the last stages
  logic [61:0] sx_q [SqrtSt+1];
  logic [63:0] sr_q [SqrtSt+1];
  logic [29:0] ms_q [SqrtSt+1][3];

  // divide pipeline
  logic [31:0] len_q [DivSt+1];
  logic [32:0] rm_q [DivSt+1][3];
  logic [31:0] qt_q [DivSt+1][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[Depth-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sd_q[0].zero <= (mx == '0);
      sd_q[0].neg <= {vec_i[2][InBits-1], vec_i[1][InBits-1], vec_i[0][InBits-1]};
      sd_q[0].tag <= tag_i;
      m0_q <= m0_d;
      for (int s = 1; s < Depth; s++) sd_q[s] <= sd_q[s-1];
      sq_q <= 62'(m0_q[0] * m0_q[0]) + 62'(m0_q[1] * m0_q[1]) + 62'(m0_q[2] * m0_q[2]);
      m1_q <= m0_q;
    end
  end

  assign sx_q[0] = sq_q;
  assign sr_q[0] = '0;
  assign ms_q[0] = m1_q;

  for (genvar s = 0; s < SqrtSt; s++) begin : g_sqrt
    localparam logic [63:0] Bit = 64'(1) << (62 - 2 * s);
    logic [63:0] trial;
    logic [63:0] x_ext;
    logic [63:0] r_ext;
    assign x_ext = 64'(sx_q[s]);
    assign r_ext = sr_q[s];
    assign trial = r_ext + Bit;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (x_ext >= trial) begin
          sx_q[s+1] <= 62'(x_ext - trial);
          sr_q[s+1] <= (r_ext >> 1) + Bit;
        end else begin
          sx_q[s+1] <= sx_q[s];
          sr_q[s+1] <= r_ext >> 1;
        end
        ms_q[s+1] <= ms_q[s];
      end
    end
  end

  // long division of (m << 30) + len/2 by len; numerator < 2^61 so 32 quotient bits
  logic [31:0] len0;
  assign len0 = (sr_q[SqrtSt] == '0) ? 32'd1 : 32'(sr_q[SqrtSt]);
  assign len_q[0] = len0;
  for (genvar i = 0; i < 3; i++) begin : g_dinit
    logic [61:0] num;
    assign num = (62'(ms_q[SqrtSt][i]) << 30) + 62'(len0 >> 1);
    // the 32 top bits [61:30] go through the remainder first, giving the high quotient bits
    assign rm_q[0][i] = '0;
    assign qt_q[0][i] = 32'(num >> 30);
  end
  logic [29:0] lo_q [DivSt+1][3];
  for (genvar i = 0; i < 3; i++) begin : g_lo
    logic [61:0] numl;
    assign numl = (62'(ms_q[SqrtSt][i]) << 30) + 62'(len0 >> 1);
    assign lo_q[0][i] = numl[29:0];
  end

  // qt holds pending numerator high bits, shifted out MSB first then quotient in
  for (genvar s = 0; s < DivSt; s++) begin : g_div
    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [32:0] r_sh;
      assign r_sh = {rm_q[s][i][31:0], qt_q[s][i][31]};
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (r_sh >= 33'(len_q[s])) begin
            rm_q[s+1][i] <= r_sh - 33'(len_q[s]);
            qt_q[s+1][i] <= {qt_q[s][i][30:0], 1'b1};
          end else begin
            rm_q[s+1][i] <= r_sh;
            qt_q[s+1][i] <= {qt_q[s][i][30:0], 1'b0};
          end
          lo_q[s+1][i] <= lo_q[s][i];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) len_q[s+1] <= len_q[s];
    end
  end

  // finish with the low 30 numerator bits: combine remainder path
  // quotient = ((hi*2^30 + lo) / len); hi-part division above gives q_hi, r_hi
  // q = q_hi*2^30 + (r_hi*2^30 + lo)/len; r_hi < len < 2^31 so second part < 2^30
  // second part done in stages below
  localparam int unsigned LoSt = 30;
  logic [31:0] len2_q [LoSt+1];
  logic [31:0] r2_q [LoSt+1][3];
  logic [29:0] q2_q [LoSt+1][3];
  logic [29:0] l2_q [LoSt+1][3];
  logic [1:0]  qh_q [LoSt+1][3];
  logic [LoSt-1:0] v2_q;
  side_t sd2_q [LoSt];

  assign len2_q[0] = len_q[DivSt];
  for (genvar i = 0; i < 3; i++) begin : g_l0
    assign r2_q[0][i] = rm_q[DivSt][i][31:0];
    assign q2_q[0][i] = '0;
    assign l2_q[0][i] = lo_q[DivSt][i];
    assign qh_q[0][i] = qt_q[DivSt][i][1:0];
  end
  for (genvar s = 0; s < LoSt; s++) begin : g_div2
    for (genvar i = 0; i < 3; i++) begin : g_lane2
      logic [32:0] r_sh;
      assign r_sh = {r2_q[s][i], l2_q[s][i][29]};
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (r_sh >= 33'(len2_q[s])) begin
            r2_q[s+1][i] <= 32'(r_sh - 33'(len2_q[s]));
            q2_q[s+1][i] <= {q2_q[s][i][28:0], 1'b1};
          end else begin
            r2_q[s+1][i] <= 32'(r_sh);
            q2_q[s+1][i] <= {q2_q[s][i][28:0], 1'b0};
          end
          l2_q[s+1][i] <= {l2_q[s][i][28:0], 1'b0};
          qh_q[s+1][i] <= qh_q[s][i];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) len2_q[s+1] <= len2_q[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= '0;
    end else if (en_i) begin
      v2_q <= {v2_q[LoSt-2:0], v_q[Depth-1]};
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sd2_q[0] <= sd_q[Depth-1];
      for (int s = 1; s < LoSt; s++) sd2_q[s] <= sd2_q[s-1];
    end
  end

  assign valid_o = v2_q[LoSt-1];
  assign zero_o = sd2_q[LoSt-1].zero;
  assign tag_o = sd2_q[LoSt-1].tag;
  for (genvar i = 0; i < 3; i++) begin : g_out
    logic [31:0] q;
    assign q = {qh_q[LoSt][i], q2_q[LoSt][i]};
    assign unit_o[i] = sd2_q[LoSt-1].neg[i] ? -$signed(q) : $signed(q);
  end
endmodule

/* rtl/billboard_basis_matrix.sv */
// Top level: pipelined billboard rotation basis from a camera item.
//  channel | dir | handshake     | payload
//  cam     | in  | valid/ready   | eye, target, up (Q16.16)
//  basis   | out | valid/ready   | three rows (Q2.OUT_FRAC_BITS), degenerate
//  cfg     | in  | cfg_we_i      | index 0 x enable, 1 y enable
// One item per cycle unless the output stalls; 196 register stages in all:
// two normalizers of 96 (square root two bits a stage, division one bit a
// stage), two cross-product stages, one product stage and the output register.
// A stall on the output freezes the whole pipeline; valid bits clear on reset.
module billboard_basis_matrix #(
  parameter int unsigned OUT_FRAC_BITS = 14
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [bbm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic                     cfg_data_i,
  bbm_cam_if.sink                  cam,
  bbm_basis_if.source              basis
);
  import bbm_pkg::*;

  localparam int unsigned RShift = 30 - OUT_FRAC_BITS;
  localparam int unsigned TagW = 3 + 96;
  localparam logic signed [31:0] One30 = 32'sd1 << 30;

  logic x_en_q, y_en_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_en_q <= 1'b0;
      y_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_X_ENABLE: x_en_q <= cfg_data_i;
        CFG_Y_ENABLE: y_en_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // output register with stall
  logic        out_v_q;
  basis_item_t out_q;
  logic        en;
  assign en = !out_v_q || basis.ready;
  assign cam.ready = en;

  // normalizer A: forward
  logic signed [63:0] d [3];
  lane_ctl_t ctl_in;
  assign d[0] = 64'(cam.data.target_x) - 64'(cam.data.eye_x);
  assign d[1] = 64'(cam.data.target_y) - 64'(cam.data.eye_y);
  assign d[2] = 64'(cam.data.target_z) - 64'(cam.data.eye_z);
  assign ctl_in.bypass = !x_en_q && !y_en_q;
  assign ctl_in.ymode = y_en_q;
  assign ctl_in.degen = 1'b0;

  logic [TagW-1:0] tag_a_in, tag_a_out;
  assign tag_a_in = {ctl_in, cam.data.up_x, cam.data.up_y, cam.data.up_z};

  logic              a_v, a_zero;
  logic signed [31:0] fwd [3];
  bbm_norm #(.InBits(64), .TagW(TagW)) u_norm_f (
    .clk_i, .rst_ni, .en_i(en), .valid_i(cam.valid && en), .vec_i(d), .tag_i(tag_a_in),
    .valid_o(a_v), .zero_o(a_zero), .unit_o(fwd), .tag_o(tag_a_out)
  );

  lane_ctl_t ctl_a;
  logic signed [31:0] up_v [3];
  assign ctl_a = tag_a_out[TagW-1 -: 3];
  assign up_v[0] = tag_a_out[95:64];
  assign up_v[1] = tag_a_out[63:32];
  assign up_v[2] = tag_a_out[31:0];

  // cross up x fwd: products registered, then subtract
  logic signed [63:0] p_q [6];
  logic signed [31:0] f1_q [3];
  lane_ctl_t c1_q;
  logic v1_q;
  logic signed [63:0] t_q [3];
  logic signed [31:0] f2_q [3];
  lane_ctl_t c2_q;
  logic v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= a_v;
      v2_q <= v1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0] <= up_v[1] * fwd[2];
      p_q[1] <= up_v[2] * fwd[1];
      p_q[2] <= up_v[2] * fwd[0];
      p_q[3] <= up_v[0] * fwd[2];
      p_q[4] <= up_v[0] * fwd[1];
      p_q[5] <= up_v[1] * fwd[0];
      f1_q <= fwd;
      c1_q <= '{bypass: ctl_a.bypass, ymode: ctl_a.ymode, degen: a_zero};
      t_q[0] <= p_q[0] - p_q[1];
      t_q[1] <= p_q[2] - p_q[3];
      t_q[2] <= p_q[4] - p_q[5];
      f2_q <= f1_q;
      c2_q <= c1_q;
    end
  end

  // normalizer B: right
  logic [TagW-1:0] tag_b_in, tag_b_out;
  assign tag_b_in = {c2_q, f2_q[0], f2_q[1], f2_q[2]};
  logic              b_v, b_zero;
  logic signed [31:0] rgt [3];
  bbm_norm #(.InBits(64), .TagW(TagW)) u_norm_r (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2_q), .vec_i(t_q), .tag_i(tag_b_in),
    .valid_o(b_v), .zero_o(b_zero), .unit_o(rgt), .tag_o(tag_b_out)
  );

  lane_ctl_t ctl_b;
  logic signed [31:0] f3 [3];
  assign ctl_b = tag_b_out[TagW-1 -: 3];
  assign f3[0] = tag_b_out[95:64];
  assign f3[1] = tag_b_out[63:32];
  assign f3[2] = tag_b_out[31:0];

  // cross fwd x rgt, products registered
  logic signed [63:0] q_q [6];
  logic signed [31:0] r4_q [3];
  logic signed [31:0] f4_q [3];
  logic v4_q, bad4_q, byp4_q, ym4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= b_v;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      q_q[0] <= f3[1] * rgt[2];
      q_q[1] <= f3[2] * rgt[1];
      q_q[2] <= f3[2] * rgt[0];
      q_q[3] <= f3[0] * rgt[2];
      q_q[4] <= f3[0] * rgt[1];
      q_q[5] <= f3[1] * rgt[0];
      r4_q <= rgt;
      f4_q <= f3;
      bad4_q <= ctl_b.bypass || ctl_b.degen || b_zero;
      byp4_q <= ctl_b.bypass;
      ym4_q <= ctl_b.ymode;
    end
  end

  function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v, input int sh);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'(1) << (sh - 1))) >> sh;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [OutW-1:0] to_out(input logic signed [63:0] q30);
    logic signed [63:0] r;
    r = (RShift > 0) ? rnd_sh(q30, RShift) : q30;
    if (r > 64'sd32767) r = 64'sd32767;
    if (r < -64'sd32768) r = -64'sd32768;
    return r[OutW-1:0];
  endfunction

  logic signed [63:0] rg [3], uw [3], fw [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rg[i] = 64'(r4_q[i]);
    end
    uw[0] = rnd_sh(q_q[0] - q_q[1], 30);
    uw[1] = rnd_sh(q_q[2] - q_q[3], 30);
    uw[2] = rnd_sh(q_q[4] - q_q[5], 30);
    for (int i = 0; i < 3; i++) fw[i] = 64'(f4_q[i]);
    if (ym4_q) begin
      uw[0] = '0; uw[1] = 64'(One30); uw[2] = '0;
      fw[0] = -64'(r4_q[2]); fw[1] = '0; fw[2] = 64'(r4_q[0]);
    end
    if (bad4_q) begin
      for (int i = 0; i < 3; i++) begin
        rg[i] = (i == 0) ? 64'(One30) : '0;
        uw[i] = (i == 1) ? 64'(One30) : '0;
        fw[i] = (i == 2) ? 64'(One30) : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.right_x <= to_out(rg[0]);
      out_q.right_y <= to_out(rg[1]);
      out_q.right_z <= to_out(rg[2]);
      out_q.upward_x <= to_out(uw[0]);
      out_q.upward_y <= to_out(uw[1]);
      out_q.upward_z <= to_out(uw[2]);
      out_q.forward_x <= to_out(fw[0]);
      out_q.forward_y <= to_out(fw[1]);
      out_q.forward_z <= to_out(fw[2]);
      out_q.degenerate <= bad4_q && !byp4_q;
    end
  end

  assign basis.valid = out_v_q;
  assign basis.data = out_q;
endmodule

/* rtl/bbm_checker.sv */
// Checker: port-level properties of the billboard basis matrix, bound to the top.
module bbm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic degen_i,
  input logic [15:0] rx_i,
  input logic [15:0] uy_i
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("result dropped");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i) else $error("not ready with empty output");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i) else $error("accepted during stall");
  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && degen_i |-> rx_i != 16'h0 && uy_i != 16'h0)
    else $error("bad degenerate basis");
endmodule

bind billboard_basis_matrix bbm_checker u_bbm_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(cam.valid), .in_ready_i(cam.ready),
  .out_valid_i(basis.valid), .out_ready_i(basis.ready),
  .degen_i(basis.data.degenerate),
  .rx_i(basis.data.right_x), .uy_i(basis.data.upward_y)
);

/* verif/tb_billboard_basis_matrix.sv */
// Testbench for billboard_basis_matrix: random and directed camera items checked against a predictor.
`timescale 1ns / 100ps

module tb_billboard_basis_matrix;
  import bbm_pkg::*;

  typedef longint vec3_t [0:2];

  localparam int unsigned FracBits = 14;
  localparam int unsigned Drain = 400;
  localparam int unsigned CycleLimit = 600000;
  localparam longint One30 = 64'sd1 << 30;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic cfg_data_i;

  bbm_cam_if cam_ch ();
  bbm_basis_if basis_ch ();

  billboard_basis_matrix #(.OUT_FRAC_BITS(FracBits)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cam        (cam_ch.sink),
    .basis      (basis_ch.source)
  );

  cam_item_t   cam_pending [$];
  basis_item_t basis_expected [$];
  bit x_en, y_en;
  int snd_idle_pct, rcv_idle_pct;
  bit hold_go;
  int hold_cnt;
  int errors;
  int n_sent, n_got, n_degen;
  int unsigned cycles;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic longint unsigned mag(longint v);
    return v < 0 ? 64'd0 - longint'(unsigned'(v)) : longint'(unsigned'(v));
  endfunction

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic bit unit_vec(input vec3_t c, output vec3_t o);
    longint unsigned m [0:2];
    longint unsigned mx, sq, len, q;
    mx = 0;
    sq = 0;
    o = '{0, 0, 0};
    for (int i = 0; i < 3; i++) begin
      m[i] = mag(c[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return 1'b0;
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      mx = mx >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      mx = mx << 1;
    end
    for (int i = 0; i < 3; i++) sq = sq + m[i] * m[i];
    len = isqrt(sq);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 30) + (len >> 1)) / len;
      o[i] = c[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic longint rnd_shift(longint v, int unsigned sh);
    longint unsigned m;
    m = mag(v);
    if (sh > 0) m = (m + (64'd1 << (sh - 1))) >> sh;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [OutW-1:0] to_q(longint q30);
    longint r;
    r = rnd_shift(q30, 30 - FracBits);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[OutW-1:0];
  endfunction

  function automatic vec3_t crossp(vec3_t a, vec3_t b);
    vec3_t o;
    o[0] = a[1] * b[2] - a[2] * b[1];
    o[1] = a[2] * b[0] - a[0] * b[2];
    o[2] = a[0] * b[1] - a[1] * b[0];
    return o;
  endfunction

  function automatic basis_item_t predict_basis(cam_item_t c);
    vec3_t d, up, fwd, rgt, upw, t;
    bit ok;
    basis_item_t b;
    d[0] = longint'(c.target_x) - longint'(c.eye_x);
    d[1] = longint'(c.target_y) - longint'(c.eye_y);
    d[2] = longint'(c.target_z) - longint'(c.eye_z);
    up[0] = longint'(c.up_x);
    up[1] = longint'(c.up_y);
    up[2] = longint'(c.up_z);
    rgt = '{0, 0, 0};
    upw = '{0, 0, 0};
    fwd = '{0, 0, 0};
    ok = 1'b0;
    if (x_en || y_en) begin
      ok = unit_vec(d, fwd);
      if (ok) begin
        t = crossp(up, fwd);
        ok = unit_vec(t, rgt);
      end
      if (ok) begin
        if (y_en) begin
          upw = '{0, One30, 0};
          fwd = '{-rgt[2], 0, rgt[0]};
        end else begin
          t = crossp(fwd, rgt);
          for (int i = 0; i < 3; i++) upw[i] = rnd_shift(t[i], 30);
        end
      end
    end
    if (!ok) begin
      rgt = '{One30, 0, 0};
      upw = '{0, One30, 0};
      fwd = '{0, 0, One30};
    end
    b.right_x = to_q(rgt[0]);
    b.right_y = to_q(rgt[1]);
    b.right_z = to_q(rgt[2]);
    b.upward_x = to_q(upw[0]);
    b.upward_y = to_q(upw[1]);
    b.upward_z = to_q(upw[2]);
    b.forward_x = to_q(fwd[0]);
    b.forward_y = to_q(fwd[1]);
    b.forward_z = to_q(fwd[2]);
    b.degenerate = !ok && (x_en || y_en);
    return b;
  endfunction

  // driver
  always @(posedge clk_i) begin
    cam_item_t nxt;
    bit offer;
    if (rst_ni) begin
      offer = cam_ch.valid;
      if (cam_ch.valid && cam_ch.ready) begin
        basis_expected.push_back(predict_basis(cam_ch.data));
        n_sent++;
        offer = 1'b0;
      end
      if (!offer && cam_pending.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
        nxt = cam_pending.pop_front();
        cam_ch.data <= nxt;
        offer = 1'b1;
      end
      cam_ch.valid <= offer;
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_go && hold_cnt == 0) hold_cnt <= 600;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
  end

  // monitor
  always @(posedge clk_i) begin
    basis_item_t e, a;
    if (rst_ni) begin
      if (basis_ch.valid && basis_ch.ready) begin
        a = basis_ch.data;
        n_got++;
        if (a.degenerate) n_degen++;
        if (basis_expected.size() == 0) begin
          $error("unexpected basis item");
          errors++;
        end else begin
          e = basis_expected.pop_front();
          if (a.right_x !== e.right_x) begin
            $error("right_x exp %0d got %0d", e.right_x, a.right_x); errors++;
          end
          if (a.right_y !== e.right_y) begin
            $error("right_y exp %0d got %0d", e.right_y, a.right_y); errors++;
          end
          if (a.right_z !== e.right_z) begin
            $error("right_z exp %0d got %0d", e.right_z, a.right_z); errors++;
          end
          if (a.upward_x !== e.upward_x) begin
            $error("upward_x exp %0d got %0d", e.upward_x, a.upward_x); errors++;
          end
          if (a.upward_y !== e.upward_y) begin
            $error("upward_y exp %0d got %0d", e.upward_y, a.upward_y); errors++;
          end
          if (a.upward_z !== e.upward_z) begin
            $error("upward_z exp %0d got %0d", e.upward_z, a.upward_z); errors++;
          end
          if (a.forward_x !== e.forward_x) begin
            $error("forward_x exp %0d got %0d", e.forward_x, a.forward_x); errors++;
          end
          if (a.forward_y !== e.forward_y) begin
            $error("forward_y exp %0d got %0d", e.forward_y, a.forward_y); errors++;
          end
          if (a.forward_z !== e.forward_z) begin
            $error("forward_z exp %0d got %0d", e.forward_z, a.forward_z); errors++;
          end
          if (a.degenerate !== e.degenerate) begin
            $error("degenerate exp %0d got %0d", e.degenerate, a.degenerate); errors++;
          end
        end
      end
      basis_ch.ready <= (hold_cnt == 0) && ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_cfg(cfg_idx_e idx, bit val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_X_ENABLE) x_en = val;
    else y_en = val;
  endtask

  task automatic wait_idle();
    while (cam_pending.size() != 0 || cam_ch.valid || basis_expected.size() != 0)
      @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic add_cam(logic [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz);
    cam_item_t c;
    c = '{ex, ey, ez, tx, ty, tz, ux, uy, uz};
    cam_pending.push_back(c);
  endtask

  function automatic logic [31:0] rnd_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(200000) - 100000;
      default: return ($urandom_range(64) - 32) <<< 16;
    endcase
  endfunction

  task automatic add_random(int n);
    logic [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz;
    int mode, k;
    for (int i = 0; i < n; i++) begin
      mode = $urandom_range(2);
      ex = rnd_coord(mode); ey = rnd_coord(mode); ez = rnd_coord(mode);
      tx = rnd_coord(mode); ty = rnd_coord(mode); tz = rnd_coord(mode);
      ux = rnd_coord(mode); uy = rnd_coord(mode); uz = rnd_coord(mode);
      k = $urandom_range(19);
      if (k == 0) begin
        tx = ex; ty = ey; tz = ez;
      end else if (k == 1 && mode != 0) begin
        // up parallel to view direction
        ux = tx - ex; uy = ty - ey; uz = tz - ez;
      end else if (k == 2) begin
        ux = 0; uy = 32'h0001_0000; uz = 0;
      end
      add_cam(ex, ey, ez, tx, ty, tz, ux, uy, uz);
    end
  endtask

  task automatic add_directed();
    add_cam(0, 0, 0, 0, 0, 32'h0001_0000, 0, 32'h0001_0000, 0);
    add_cam(1, 2, 3, 1, 2, 3, 0, 32'h0001_0000, 0);
    add_cam(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    add_cam(32'h8000_0000, 0, 32'h7fff_ffff, 32'h7fff_ffff, 0, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_cam(0, 0, 0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000, 0);
    add_cam(0, 0, 0, 5, 7, 9, 10, 14, 18);
    add_cam(0, 0, 0, 1, 0, 0, 0, 0, 1);
    add_cam(0, 0, 0, 0, 0, 1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    add_cam(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0, 0, 32'h7fff_ffff, 0);
    add_cam(0, 0, 0, 32'h0000_8000, 32'h0001_0000, 32'h0000_4000, 0, 32'h0001_0000, 0);
  endtask

  initial begin
    bit xs [6] = '{0, 1, 0, 1, 1, 0};
    bit ys [6] = '{0, 0, 1, 1, 0, 1};
    errors = 0;
    n_sent = 0;
    n_got = 0;
    n_degen = 0;
    cycles = 0;
    hold_go = 1'b0;
    hold_cnt = 0;
    x_en = 0;
    y_en = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_X_ENABLE;
    cfg_data_i = 1'b0;
    cam_ch.valid = 1'b0;
    cam_ch.data = '0;
    basis_ch.ready = 1'b0;
    snd_idle_pct = 9;
    rcv_idle_pct = 54;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < 6; p++) begin
      if (p < 2) begin
        snd_idle_pct = 9; rcv_idle_pct = 54;
      end else if (p < 4) begin
        snd_idle_pct = 54; rcv_idle_pct = 9;
      end else begin
        snd_idle_pct = 0; rcv_idle_pct = 0;
      end
      write_cfg(CFG_X_ENABLE, xs[p]);
      write_cfg(CFG_Y_ENABLE, ys[p]);
      if (p < 4) add_directed();
      if (p == 4) begin
        @(posedge clk_i);
        hold_go <= 1'b1;
        @(posedge clk_i);
        hold_go <= 1'b0;
      end
      add_random(140);
      if (p == 1) begin
        // sender waits for every result before going on
        while (cam_pending.size() != 0 || cam_ch.valid || basis_expected.size() != 0)
          @(posedge clk_i);
      end
      add_random(140);
      wait_idle();
    end
    $display("sent %0d camera items over six flag settings, got %0d basis items",
             n_sent, n_got);
    $display("%0d degenerate results, %0d mismatches", n_degen, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
